/* src/cvb_pkg.sv */
// Shared types, constants and arithmetic helpers for the CAPPI vertical blend block.
// No dependencies; compile first.
package cvb_pkg;

  localparam int SampleWidth = 16;
  localparam int PctWidth    = 7;
  localparam int PctFull     = 100;
  localparam int PctHalf     = 50;
  localparam int PipeDepth   = 5;

  // Weighted sums: |sample| * 200 + 50 fits with room to spare.
  localparam int NumWidth   = SampleWidth + 9;
  // Quotient of a weighted sum by one hundred.
  localparam int QuoWidth   = SampleWidth + 3;
  // Reciprocal multiply for division by one hundred: exact for |x| < 2^(NumWidth-1).
  localparam int RecipShift = NumWidth + 6;
  localparam int ProdWidth  = 2 * NumWidth - 1;
  localparam logic [NumWidth-1:0] RecipMul =
    NumWidth'(((64'd1 << RecipShift) + 64'd99) / 64'd100);

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [PctWidth-1:0]           pct_t;
  typedef logic signed [NumWidth-1:0]    num_t;

  localparam sample_t SampleMax = {1'b0, {(SampleWidth - 1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleWidth - 1){1'b0}}};

  localparam sample_t NoechoReset        = SampleMin;
  localparam sample_t ValidFloorReset    = SampleWidth'(-500);
  localparam sample_t FallbackFloorReset = SampleWidth'(-1600);
  localparam sample_t EchoFloorReset     = SampleWidth'(-700);

  typedef enum logic [1:0] {
    ModeSkip  = 2'd0,
    ModeLower = 2'd1,
    ModeBlend = 2'd2,
    ModeUpper = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CfgNoecho        = 2'd0,
    CfgValidFloor    = 2'd1,
    CfgFallbackFloor = 2'd2,
    CfgEchoFloor     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic load_s1;
    logic load_s2;
  } sweep_ctl_t;

  typedef struct packed {
    logic load_s3;
    logic load_s4;
  } blend_ctl_t;

  typedef struct packed {
    mode_e   mode;
    logic    upper_in_range;
    sample_t upper_near;
    sample_t upper_far;
    pct_t    upper_frac;
    logic    lower_in_range;
    sample_t lower_near;
    sample_t lower_far;
    pct_t    lower_frac;
    pct_t    upper_weight;
    pct_t    lower_weight;
  } gate_t;

  // Clamp a percent field at one hundred.
  function automatic pct_t sat_pct(input pct_t v);
    return (v > pct_t'(PctFull)) ? pct_t'(PctFull) : v;
  endfunction

  // Signed division by one hundred, truncating toward zero.
  function automatic logic signed [QuoWidth-1:0] div_pct(input num_t num);
    logic [NumWidth-2:0]  mag;
    logic [ProdWidth-1:0] prod;
    logic [QuoWidth-1:0]  quo;
    mag  = num[NumWidth-1] ? (NumWidth-1)'(-num) : num[NumWidth-2:0];
    prod = ProdWidth'(mag) * ProdWidth'(RecipMul);
    quo  = QuoWidth'(prod >> RecipShift);
    return num[NumWidth-1] ? $signed(-quo) : $signed(quo);
  endfunction

endpackage

/* src/cvb_gate_if.sv */
// Input channel of the CAPPI vertical blend block: one output gate request.
// Depends on cvb_pkg.
interface cvb_gate_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             mode;
  logic                                   upper_in_range;
  logic signed [cvb_pkg::SampleWidth-1:0] upper_near;
  logic signed [cvb_pkg::SampleWidth-1:0] upper_far;
  logic [cvb_pkg::PctWidth-1:0]           upper_frac;
  logic                                   lower_in_range;
  logic signed [cvb_pkg::SampleWidth-1:0] lower_near;
  logic signed [cvb_pkg::SampleWidth-1:0] lower_far;
  logic [cvb_pkg::PctWidth-1:0]           lower_frac;
  logic [cvb_pkg::PctWidth-1:0]           upper_weight;
  logic [cvb_pkg::PctWidth-1:0]           lower_weight;

  modport source (
    output valid, mode, upper_in_range, upper_near, upper_far, upper_frac,
           lower_in_range, lower_near, lower_far, lower_frac, upper_weight, lower_weight,
    input  ready
  );

  modport sink (
    input  valid, mode, upper_in_range, upper_near, upper_far, upper_frac,
           lower_in_range, lower_near, lower_far, lower_frac, upper_weight, lower_weight,
    output ready
  );
endinterface

/* src/cvb_level_if.sv */
// Output channel of the CAPPI vertical blend block: one constant-altitude level value.
// Depends on cvb_pkg.
interface cvb_level_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cvb_pkg::SampleWidth-1:0] level_value;

  modport source (output valid, level_value, input ready);
  modport sink   (input valid, level_value, output ready);
endinterface

/* src/cvb_sweep.sv */
// One elevation sweep: range interpolation or fallback, and the held sweep value.
// Depends on cvb_pkg.
module cvb_sweep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cvb_pkg::sweep_ctl_t ctl_i,
  input  logic                in_range_i,
  input  cvb_pkg::sample_t    near_i,
  input  cvb_pkg::sample_t    far_i,
  input  cvb_pkg::pct_t       frac_i,
  input  cvb_pkg::sample_t    valid_floor_i,
  input  cvb_pkg::sample_t    fallback_floor_i,
  output cvb_pkg::sample_t    value_o
);
  import cvb_pkg::*;

  logic    in_range_q;
  logic    interp_q, interp_d;
  num_t    num_q, num_d;
  sample_t fb_q, fb_d;
  sample_t held_q, held_d;

  // Stage one: weighted sum and fallback candidate.
  always_comb begin
    pct_t    frac_s;
    num_t    near_x;
    num_t    far_x;
    num_t    w_far;
    num_t    w_near;
    sample_t hi;
    frac_s   = sat_pct(frac_i);
    near_x   = NumWidth'(near_i);
    far_x    = NumWidth'(far_i);
    w_far    = NumWidth'({1'b0, frac_s});
    w_near   = NumWidth'(PctFull) - w_far;
    num_d    = near_x * w_near + far_x * w_far + NumWidth'(PctHalf);
    interp_d = (near_i > valid_floor_i) && (far_i > valid_floor_i);
    hi       = (near_i > far_i) ? near_i : far_i;
    fb_d     = (hi < fallback_floor_i) ? fallback_floor_i : hi;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_s1) begin
      in_range_q <= in_range_i;
      interp_q   <= interp_d;
      num_q      <= num_d;
      fb_q       <= fb_d;
    end
  end

  // Stage two: divide and keep the last value when out of range.
  always_comb begin
    held_d = held_q;
    if (ctl_i.load_s2 && in_range_q) begin
      held_d = interp_q ? SampleWidth'(div_pct(num_q)) : fb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= SampleMin;
    end else begin
      held_q <= held_d;
    end
  end

  assign value_o = held_q;

  a_held_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.load_s2 |=> $stable(held_q))
    else $error("held sweep value changed without a stage-two load");

endmodule

/* src/cvb_blend.sv */
// Mode selection, vertical blend, saturation and echo floor test.
// Depends on cvb_pkg.
module cvb_blend (
  input  logic                clk_i,
  input  cvb_pkg::blend_ctl_t ctl_i,
  input  cvb_pkg::mode_e      mode_i,
  input  cvb_pkg::sample_t    upper_i,
  input  cvb_pkg::sample_t    lower_i,
  input  cvb_pkg::pct_t       upper_weight_i,
  input  cvb_pkg::pct_t       lower_weight_i,
  input  cvb_pkg::sample_t    echo_floor_i,
  input  cvb_pkg::sample_t    noecho_i,
  output cvb_pkg::sample_t    level_o
);
  import cvb_pkg::*;

  logic    blend_q, blend_d;
  num_t    num_q, num_d;
  sample_t level_q, level_d;

  // Stage three: pick a sweep or form the weighted vertical sum.
  always_comb begin
    num_t wu;
    num_t wl;
    wu      = NumWidth'({1'b0, sat_pct(upper_weight_i)});
    wl      = NumWidth'({1'b0, sat_pct(lower_weight_i)});
    blend_d = 1'b0;
    case (mode_i)
      ModeLower: num_d = NumWidth'(lower_i);
      ModeUpper: num_d = NumWidth'(upper_i);
      ModeBlend: begin
        blend_d = 1'b1;
        num_d   = NumWidth'(lower_i) * wl + NumWidth'(upper_i) * wu + NumWidth'(PctHalf);
      end
      default:   num_d = NumWidth'(lower_i);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_s3) begin
      blend_q <= blend_d;
      num_q   <= num_d;
    end
  end

  // Stage four: divide, saturate, apply the echo floor.
  always_comb begin
    logic signed [QuoWidth-1:0] quo;
    sample_t                    r;
    quo = div_pct(num_q);
    if (!blend_q) begin
      r = num_q[SampleWidth-1:0];
    end else if (quo > QuoWidth'(SampleMax)) begin
      r = SampleMax;
    end else if (quo < QuoWidth'(SampleMin)) begin
      r = SampleMin;
    end else begin
      r = quo[SampleWidth-1:0];
    end
    level_d = (r < echo_floor_i) ? noecho_i : r;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_s4) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

/* src/cappi_vertical_blend_top.sv */
// Top level of the CAPPI vertical blend block: request pipeline, config registers.
// Depends on cvb_pkg, cvb_gate_if, cvb_level_if, cvb_sweep and cvb_blend.
//
//   Port          Dir  Handshake    Carries
//   gate_in       in   valid/ready  mode, two sweeps of near/far/frac, vertical weights
//   level_out     out  valid/ready  level_value
//   cfg_*_i       in   write enable noecho_code, valid_floor, fallback_floor, echo_floor
//
// One request is taken per cycle while the output is not stalled; its result is offered
// from the output register once it has passed through every stage.
// The five stages are: input register, sweep sums, sweep divide and held values,
// blend sum, blend divide and echo floor (output register).
// Each stage holds only while it is full and the stage after it is stalled, so
// bubbles close up and requests keep flowing while a result waits.
// Mode-skip requests are accepted and dropped at the input register.
// Reset clears every stage valid, loads the config defaults and sets both held
// sweep values to the minimum sample.
module cappi_vertical_blend_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  cvb_gate_if.sink          gate_in,
  cvb_level_if.source       level_out,
  input  logic              cfg_we_i,
  input  cvb_pkg::cfg_reg_e cfg_idx_i,
  input  cvb_pkg::sample_t  cfg_wdata_i
);
  import cvb_pkg::*;

  // Config registers.
  sample_t noecho_q;
  sample_t valid_floor_q;
  sample_t fallback_floor_q;
  sample_t echo_floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noecho_q         <= NoechoReset;
      valid_floor_q    <= ValidFloorReset;
      fallback_floor_q <= FallbackFloorReset;
      echo_floor_q     <= EchoFloorReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNoecho:        noecho_q         <= cfg_wdata_i;
        CfgValidFloor:    valid_floor_q    <= cfg_wdata_i;
        CfgFallbackFloor: fallback_floor_q <= cfg_wdata_i;
        CfgEchoFloor:     echo_floor_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage advance. A stage may load when it is empty
  // or the stage after it is moving.
  logic [PipeDepth-1:0] vld_q, vld_d;
  logic [PipeDepth-1:0] adv;
  mode_e                in_mode;

  assign in_mode = mode_e'(gate_in.mode);

  always_comb begin
    adv[PipeDepth-1] = !vld_q[PipeDepth-1] || level_out.ready;
    for (int k = PipeDepth - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    // Drop skip requests: they update nothing and produce no result.
    vld_d[0] = adv[0] ? (gate_in.valid && (in_mode != ModeSkip)) : vld_q[0];
    for (int k = 1; k < PipeDepth; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign gate_in.ready = adv[0];

  // Input register.
  gate_t s0_q;

  always_ff @(posedge clk_i) begin
    if (adv[0] && gate_in.valid) begin
      s0_q.mode           <= in_mode;
      s0_q.upper_in_range <= gate_in.upper_in_range;
      s0_q.upper_near     <= gate_in.upper_near;
      s0_q.upper_far      <= gate_in.upper_far;
      s0_q.upper_frac     <= gate_in.upper_frac;
      s0_q.lower_in_range <= gate_in.lower_in_range;
      s0_q.lower_near     <= gate_in.lower_near;
      s0_q.lower_far      <= gate_in.lower_far;
      s0_q.lower_frac     <= gate_in.lower_frac;
      s0_q.upper_weight   <= gate_in.upper_weight;
      s0_q.lower_weight   <= gate_in.lower_weight;
    end
  end

  sweep_ctl_t sweep_ctl;
  blend_ctl_t blend_ctl;

  assign sweep_ctl.load_s1 = adv[1] && vld_q[0];
  assign sweep_ctl.load_s2 = adv[2] && vld_q[1];
  assign blend_ctl.load_s3 = adv[3] && vld_q[2];
  assign blend_ctl.load_s4 = adv[4] && vld_q[3];

  // Carry mode and vertical weights alongside the sweep stages.
  mode_e mode1_q, mode2_q;
  pct_t  uw1_q, uw2_q;
  pct_t  lw1_q, lw2_q;

  always_ff @(posedge clk_i) begin
    if (sweep_ctl.load_s1) begin
      mode1_q <= s0_q.mode;
      uw1_q   <= s0_q.upper_weight;
      lw1_q   <= s0_q.lower_weight;
    end
    if (sweep_ctl.load_s2) begin
      mode2_q <= mode1_q;
      uw2_q   <= uw1_q;
      lw2_q   <= lw1_q;
    end
  end

  // Held sweep values double as the stage-two registers.
  sample_t upper_val;
  sample_t lower_val;

  cvb_sweep u_upper (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (sweep_ctl),
    .in_range_i       (s0_q.upper_in_range),
    .near_i           (s0_q.upper_near),
    .far_i            (s0_q.upper_far),
    .frac_i           (s0_q.upper_frac),
    .valid_floor_i    (valid_floor_q),
    .fallback_floor_i (fallback_floor_q),
    .value_o          (upper_val)
  );

  cvb_sweep u_lower (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (sweep_ctl),
    .in_range_i       (s0_q.lower_in_range),
    .near_i           (s0_q.lower_near),
    .far_i            (s0_q.lower_far),
    .frac_i           (s0_q.lower_frac),
    .valid_floor_i    (valid_floor_q),
    .fallback_floor_i (fallback_floor_q),
    .value_o          (lower_val)
  );

  sample_t level;

  cvb_blend u_blend (
    .clk_i          (clk_i),
    .ctl_i          (blend_ctl),
    .mode_i         (mode2_q),
    .upper_i        (upper_val),
    .lower_i        (lower_val),
    .upper_weight_i (uw2_q),
    .lower_weight_i (lw2_q),
    .echo_floor_i   (echo_floor_q),
    .noecho_i       (noecho_q),
    .level_o        (level)
  );

  assign level_out.valid       = vld_q[PipeDepth-1];
  assign level_out.level_value = level;

  a_empty_input_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> gate_in.ready)
    else $error("input refused while the input register is empty");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(level_out.valid) |-> $past(vld_q[PipeDepth-2]))
    else $error("result appeared without a request in the blend stage");

  a_skip_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gate_in.valid && gate_in.ready && (in_mode == ModeSkip)) |=> !vld_q[0])
    else $error("skip request entered the pipeline");

endmodule
